// File: sv/asb_pkg.sv
// Shared types and codes for the accumulating stopwatch bank.
// No dependencies; imported by the controller, datapath and top level.
package asb_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_GET   = 2'd1,
    OP_STOP  = 2'd2,
    OP_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_INIT     = 2'd1,
    ST_CLEAR_ACTIVE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request, launch entry read
    logic commit;   // write back entry, load result register
  } cmd_t;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned CYCLE_W = 64;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;

endpackage

// File: sv/asb_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on asb_pkg for field widths.
interface asb_in_if import asb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [INDEX_W-1:0] timer_index;
  logic [CYCLE_W-1:0] cycle_now;

  modport source (output valid, func, timer_index, cycle_now, input ready);
  modport sink   (input valid, func, timer_index, cycle_now, output ready);
endinterface

interface asb_out_if import asb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [STAT_W-1:0]  status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// File: sv/accumulating_stopwatch_bank.sv
// Accumulating stopwatch bank. Requests execute one at a time: entry read on accept,
// write-back and result register load on commit, through the single-port stamp/total
// memories; a stalled result holds execution and no new request is accepted until commit.
// Reset (rst_n low, synchronous): all timers uninitialized and idle, no result pending.
// Depends on asb_pkg, asb_if, asb_ctrl, asb_datapath.
module accumulating_stopwatch_bank import asb_pkg::*; #(
  parameter int TIMER_COUNT = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  asb_in_if.sink    in_bus,
  asb_out_if.source out_bus
);

  cmd_t cmd;

  asb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd)
  );

  asb_datapath #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_func        (in_bus.func),
    .in_timer_index (in_bus.timer_index),
    .in_cycle_now   (in_bus.cycle_now),
    .out_value      (out_bus.value),
    .out_status     (out_bus.status)
  );

endmodule

// File: sv/asb_ctrl.sv
// Sequencer for the stopwatch bank: accept, execute, hand off result beat.
// Depends on asb_pkg (state_t, cmd_t).
module asb_ctrl import asb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // result register free, or its beat leaves this cycle
        cmd.commit = !out_valid_r || out_ready;
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.commit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_EXEC)
    else $error("request captured but no execute cycle followed");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && !cmd.commit) |=> (state_r == S_EXEC && out_valid_r))
    else $error("stalled request or pending result dropped");

endmodule

// File: sv/asb_datapath.sv
// Timer storage and arithmetic: flag vectors, stamp/total memories, result reg.
// Depends on asb_pkg (func_t, status_t, cmd_t, widths).
module asb_datapath import asb_pkg::*; #(
  parameter int TIMER_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [INDEX_W-1:0] in_timer_index,
  input  logic [CYCLE_W-1:0] in_cycle_now,
  output logic [VALUE_W-1:0] out_value,
  output logic [STAT_W-1:0]  out_status
);

  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  logic [CYCLE_W-1:0] stamp_mem [TIMER_COUNT];
  logic [CYCLE_W-1:0] total_mem [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] init_r, run_r;

  func_t              func_r;
  logic               in_range_r;
  logic [IDX_W-1:0]   addr_r;
  logic [CYCLE_W-1:0] now_r, rd_stamp_r, rd_total_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [STAT_W-1:0]  out_status_r;

  logic [IDX_W-1:0] in_addr;
  logic             in_range;
  assign in_addr  = IDX_W'(in_timer_index);
  assign in_range = 32'(in_timer_index) < 32'(TIMER_COUNT);

  // request capture; entry read data is registered on the same edge
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= func_t'(in_func);
      in_range_r <= in_range;
      addr_r     <= in_addr;
      now_r      <= in_cycle_now;
      rd_stamp_r <= stamp_mem[in_addr];
      rd_total_r <= total_mem[in_addr];
    end
  end

  logic               run_bit, init_bit;
  logic [CYCLE_W-1:0] run_sum;
  status_t            res_status;
  logic [VALUE_W-1:0] res_value;
  logic               wr_stamp, wr_total, set_init, set_run, clr_run;
  logic [CYCLE_W-1:0] wr_stamp_d, wr_total_d;

  assign run_bit  = run_r[addr_r];
  assign init_bit = init_r[addr_r];
  // total + (now - stamp), three-operand add, wraps mod 2^64
  assign run_sum  = rd_total_r + now_r + ~rd_stamp_r + CYCLE_W'(1);

  always_comb begin
    res_status = ST_OK;
    res_value  = '0;
    wr_stamp   = 1'b0;
    wr_total   = 1'b0;
    wr_stamp_d = '0;
    wr_total_d = '0;
    set_init   = 1'b0;
    set_run    = 1'b0;
    clr_run    = 1'b0;
    if (!in_range_r) begin
      res_status = ST_NOT_INIT;
    end else if (func_r == OP_CLEAR) begin
      if (run_bit) begin
        res_status = ST_CLEAR_ACTIVE;
      end else begin
        set_init = 1'b1;
        wr_stamp = 1'b1;
        wr_total = 1'b1;
      end
    end else if (!init_bit) begin
      res_status = ST_NOT_INIT;
    end else begin
      case (func_r)
        OP_START: begin
          if (!run_bit) begin
            set_run    = 1'b1;
            wr_stamp   = 1'b1;
            wr_stamp_d = now_r;
            res_value  = VALUE_W'(1);
          end
        end
        OP_STOP: begin
          if (run_bit) begin
            clr_run    = 1'b1;
            wr_total   = 1'b1;
            wr_total_d = run_sum;
            res_value  = VALUE_W'(1);
          end
        end
        OP_GET: begin
          res_value = run_bit ? run_sum[VALUE_W-1:0] : rd_total_r[VALUE_W-1:0];
        end
        default: res_value = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (wr_stamp) stamp_mem[addr_r] <= wr_stamp_d;
      if (wr_total) total_mem[addr_r] <= wr_total_d;
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
      run_r  <= '0;
    end else if (cmd.commit) begin
      if (set_init) init_r[addr_r] <= 1'b1;
      if (set_run)  run_r[addr_r]  <= 1'b1;
      if (clr_run)  run_r[addr_r]  <= 1'b0;
    end
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_start_sets_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && set_run) |=> run_r[$past(addr_r)])
    else $error("started timer not marked running");

  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_status != ST_OK) |-> !(wr_stamp || wr_total || set_init))
    else $error("faulted request modified timer state");

endmodule

// File: dv/accumulating_stopwatch_bank_tb.sv
// Self-checking testbench for the accumulating stopwatch bank: directed and random
// timer requests, predicted per beat by an in-bench timer model and checked in order.
// Depends on asb_pkg, asb_if and accumulating_stopwatch_bank.
module accumulating_stopwatch_bank_tb import asb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMER_COUNT = 32;

  typedef struct {
    func_t              func;
    logic [INDEX_W-1:0] timer_index;
    logic [CYCLE_W-1:0] cycle_now;
  } request_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  asb_in_if  in_bus ();
  asb_out_if out_bus ();

  accumulating_stopwatch_bank #(.TIMER_COUNT(TIMER_COUNT)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #5 clk = ~clk;

  // timer model state
  logic               tmr_init    [TIMER_COUNT];
  logic               tmr_running [TIMER_COUNT];
  logic [CYCLE_W-1:0] tmr_stamp   [TIMER_COUNT];
  logic [CYCLE_W-1:0] tmr_total   [TIMER_COUNT];

  request_t request_queue[$];
  result_t  expected_results[$];

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count     = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_idle_pct   = 0;
  logic        in_took        = 1'b0;
  logic [CYCLE_W-1:0] cycle_clock = '0;

  initial begin
    for (int i = 0; i < TIMER_COUNT; i++) begin
      tmr_init[i]    = 1'b0;
      tmr_running[i] = 1'b0;
      tmr_stamp[i]   = '0;
      tmr_total[i]   = '0;
    end
  end

  function automatic result_t timer_step(request_t rq);
    result_t            r;
    logic [CYCLE_W-1:0] elapsed;
    int                 t;
    t        = rq.timer_index;
    r.value  = '0;
    r.status = ST_OK;
    if (t >= TIMER_COUNT) begin
      r.status = ST_NOT_INIT;
    end else if (rq.func == OP_CLEAR) begin
      if (tmr_running[t]) begin
        r.status = ST_CLEAR_ACTIVE;
      end else begin
        tmr_init[t]    = 1'b1;
        tmr_running[t] = 1'b0;
        tmr_stamp[t]   = '0;
        tmr_total[t]   = '0;
      end
    end else if (!tmr_init[t]) begin
      r.status = ST_NOT_INIT;
    end else begin
      case (rq.func)
        OP_START: begin
          if (!tmr_running[t]) begin
            tmr_running[t] = 1'b1;
            tmr_stamp[t]   = rq.cycle_now;
            r.value        = 1;
          end
        end
        OP_STOP: begin
          if (tmr_running[t]) begin
            tmr_running[t] = 1'b0;
            tmr_total[t]   = tmr_total[t] + (rq.cycle_now - tmr_stamp[t]);
            r.value        = 1;
          end
        end
        default: begin
          elapsed = tmr_total[t];
          if (tmr_running[t]) elapsed = elapsed + (rq.cycle_now - tmr_stamp[t]);
          r.value = elapsed[VALUE_W-1:0];
        end
      endcase
    end
    return r;
  endfunction

  task automatic push_request(func_t f, int t, logic [CYCLE_W-1:0] now);
    request_t rq;
    rq.func        = f;
    rq.timer_index = t[INDEX_W-1:0];
    rq.cycle_now   = now;
    request_queue.push_back(rq);
    queued_count++;
  endtask

  // Mostly small forward steps; occasional full-range jumps and steps backwards.
  function automatic logic [CYCLE_W-1:0] next_now();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) cycle_clock = {$urandom, $urandom};
    else if (r < 12) cycle_clock = cycle_clock - $urandom_range(500);
    else cycle_clock = cycle_clock + $urandom_range(2000);
    return cycle_clock;
  endfunction

  function automatic int pick_timer();
    return ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(TIMER_COUNT - 1);
  endfunction

  task automatic queue_random(int unsigned n);
    int unsigned base;
    int          t;
    base = queued_count;
    while (queued_count - base < n) begin
      if ($urandom_range(99) < 60) begin
        // clean clear/start/get.../stop/get run on one timer
        t = pick_timer();
        push_request(OP_CLEAR, t, next_now());
        push_request(OP_START, t, next_now());
        repeat ($urandom_range(3)) push_request(OP_GET, t, next_now());
        push_request(OP_STOP, t, next_now());
        push_request(OP_GET, t, next_now());
      end else begin
        repeat ($urandom_range(1, 4))
          push_request(func_t'($urandom_range(3)), pick_timer(), next_now());
      end
    end
  endtask

  // Checked at the falling edge; the accepted count and expectations only move at the rising edge.
  task automatic wait_drain();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_results.size() != 0);
  endtask

  // driver and receiver ready
  always @(negedge clk) begin : driver
    request_t nxt;
    if (rst_n) begin
      if (!in_bus.valid || in_took) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = request_queue.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.func        <= nxt.func;
          in_bus.timer_index <= nxt.timer_index;
          in_bus.cycle_now   <= nxt.cycle_now;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    request_t rq;
    result_t  exp_r;
    in_took <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      // results leave before the beat accepted at this same edge is predicted
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   out_bus.value, out_bus.status);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_bus.value !== exp_r.value || out_bus.status !== exp_r.status) begin
            fail_count++;
            $display("%0t: expected value=%h status=%0d, got value=%h status=%0d",
                     $time, exp_r.value, exp_r.status, out_bus.value, out_bus.status);
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        rq.func        = func_t'(in_bus.func);
        rq.timer_index = in_bus.timer_index;
        rq.cycle_now   = in_bus.cycle_now;
        expected_results.push_back(timer_step(rq));
        accepted_count++;
      end
    end
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.func        = OP_START;
    in_bus.timer_index = '0;
    in_bus.cycle_now   = '0;
    out_bus.ready      = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    src_idle_pct = 18;
    snk_idle_pct = 65;

    // untouched timer, then clear and run across the 64-bit wrap
    push_request(OP_START, 0, 64'd0);
    push_request(OP_GET,   0, 64'd7);
    push_request(OP_STOP,  0, 64'd9);
    push_request(OP_CLEAR, 0, 64'd10);
    push_request(OP_GET,   0, 64'd11);
    push_request(OP_STOP,  0, 64'd12);
    push_request(OP_START, 0, 64'hFFFF_FFFF_FFFF_FFF0);
    push_request(OP_START, 0, 64'd3);
    push_request(OP_CLEAR, 0, 64'd4);
    push_request(OP_GET,   0, 64'h10);
    push_request(OP_STOP,  0, 64'h5);
    push_request(OP_GET,   0, 64'hFFFF_FFFF_FFFF_FFFF);
    // top timer: maximum delta, then cycle count going backwards
    push_request(OP_CLEAR, 31, 64'd0);
    push_request(OP_START, 31, 64'd0);
    push_request(OP_STOP,  31, 64'hFFFF_FFFF_FFFF_FFFF);
    push_request(OP_GET,   31, 64'd0);
    push_request(OP_START, 31, 64'd5);
    push_request(OP_GET,   31, 64'd3);
    push_request(OP_STOP,  31, 64'd3);
    push_request(OP_GET,   31, 64'hAAAA_AAAA_5555_5555);
    push_request(OP_CLEAR, 0, 64'd20);
    push_request(OP_GET,   0, 64'd21);
    wait_drain();

    queue_random(420);
    wait_drain();

    src_idle_pct = 65;
    snk_idle_pct = 18;
    queue_random(420);
    wait_drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    queue_random(420);
    wait_drain();

    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("accumulating_stopwatch_bank: match");
    end else begin
      $display("accumulating_stopwatch_bank: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("accumulating_stopwatch_bank: mismatch");
    $finish;
  end

endmodule
